### rtl/btes_pkg.sv
// btes_pkg: constants, calendar tables and BCD helpers for the elapsed-seconds unit
// no dependencies; imported by bcd_timestamp_elapsed_seconds_unit
`timescale 1ns / 1ps
`default_nettype none

package btes_pkg;

  // field widths
  localparam int unsigned YEAR_W   = 8;
  localparam int unsigned MONTH_W  = 5;
  localparam int unsigned DAY_W    = 6;
  localparam int unsigned HOUR_W   = 7;
  localparam int unsigned MINSEC_W = 7;
  localparam int unsigned SEC_W    = 32;

  // in-year seconds stay below 2^26, day count below 2^9
  localparam int unsigned INYEAR_W = 26;
  localparam int unsigned DAYS_W   = 9;

  localparam logic [INYEAR_W-1:0] SECS_PER_DAY  = 26'd86400;
  localparam logic [INYEAR_W-1:0] SECS_PER_HOUR = 26'd3600;
  localparam logic [INYEAR_W-1:0] SECS_PER_MIN  = 26'd60;
  localparam logic [INYEAR_W-1:0] SECS_PER_YEAR = 26'd31536000;
  localparam logic [SEC_W-1:0]    REJECT_VALUE  = 32'hFFFF_FFFE;

  // hour byte flags
  localparam logic [6:0] HOUR_12H_BIT = 7'h40;
  localparam logic [6:0] HOUR_PM_BIT  = 7'h20;
  localparam logic [6:0] HOUR_MASK    = 7'h1F;
  localparam logic [6:0] HOUR_PM_ADD  = 7'h12;

  localparam logic [3:0] NIBBLE_MASK  = 4'h0F;
  localparam logic [7:0] MONTH_MAX    = 8'd12;

  // month lengths of a common year, and days before the start of month m (index 0..12)
  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };
  localparam logic [DAYS_W-1:0] CUM_DAYS [13] = '{
    9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // two-digit bcd decode, no digit check: high*10 + low
  function automatic logic [7:0] bcd_dec(input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'b0, b[7:4] & NIBBLE_MASK};
    lo = {4'b0, b[3:0] & NIBBLE_MASK};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

  // whole days since the start of the year, months clamped to december
  function automatic logic [DAYS_W-1:0] year_days(input logic [7:0] year,
                                                  input logic [7:0] month,
                                                  input logic [7:0] day);
    logic [3:0]        m;
    logic [DAYS_W-1:0] d;
    m = (month > MONTH_MAX) ? 4'd12 : month[3:0];
    d = CUM_DAYS[m];
    if (day > 8'd1) begin
      d = d + {1'b0, day - 8'd1};
    end
    if (year[1:0] == 2'b00 && m > 4'd2) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

### rtl/bcd_timestamp_elapsed_seconds_unit.sv
// bcd_timestamp_elapsed_seconds_unit: seconds between two bcd calendar timestamps
// uses btes_pkg (tables, bcd decode, constants); one shared multiply-accumulate unit
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+---------------------------------------
// in_      | input     | in_valid / in_stall | last_* and now_* bcd timestamp fields
// out_     | output    | out_valid/out_stall | elapsed_seconds, elapsed_valid
//
// an item loads the result register after 12 steps of the shared multiply-accumulate
// unit (4 per timestamp, 4 for the difference, check folded in) and one step into the
// output register; a rejected item skips three steps.
// in_stall is high from accept until the result moves out, so the next item waits for it.
// a result held by out_stall keeps the sequencer in its last step; rst_n clears
// the sequencer and out_valid only.

module bcd_timestamp_elapsed_seconds_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [btes_pkg::YEAR_W-1:0]   in_last_year_bcd,
  input  wire logic [btes_pkg::MONTH_W-1:0]  in_last_month_bcd,
  input  wire logic [btes_pkg::DAY_W-1:0]    in_last_day_bcd,
  input  wire logic [btes_pkg::HOUR_W-1:0]   in_last_hour_raw,
  input  wire logic [btes_pkg::MINSEC_W-1:0] in_last_minute_bcd,
  input  wire logic [btes_pkg::MINSEC_W-1:0] in_last_second_bcd,
  input  wire logic [btes_pkg::YEAR_W-1:0]   in_now_year_bcd,
  input  wire logic [btes_pkg::MONTH_W-1:0]  in_now_month_bcd,
  input  wire logic [btes_pkg::DAY_W-1:0]    in_now_day_bcd,
  input  wire logic [btes_pkg::HOUR_W-1:0]   in_now_hour_raw,
  input  wire logic [btes_pkg::MINSEC_W-1:0] in_now_minute_bcd,
  input  wire logic [btes_pkg::MINSEC_W-1:0] in_now_second_bcd,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [btes_pkg::SEC_W-1:0]         out_elapsed_seconds,
  output logic                              out_elapsed_valid
);

  import btes_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_L_DAY, S_L_HR, S_L_MIN, S_L_SEC,
    S_N_DAY, S_N_HR, S_N_MIN, S_N_SEC,
    S_D_YEAR, S_D_NOW, S_D_LAST, S_D_LEAP, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // decoded operands of the captured item
  logic [7:0]          ly_r, ny_r, ly_nxt, ny_nxt;
  logic [DAYS_W-1:0]   lday_r, nday_r, lday_nxt, nday_nxt;
  logic [7:0]          lhr_r, nhr_r, lhr_nxt, nhr_nxt;
  logic [7:0]          lmin_r, nmin_r, lmin_nxt, nmin_nxt;
  logic [7:0]          lsec_r, nsec_r, lsec_nxt, nsec_nxt;

  // in-year seconds and the accumulator
  logic [INYEAR_W-1:0] ls_r, ns_r, ls_nxt, ns_nxt;
  logic [SEC_W-1:0]    acc_r, acc_nxt;
  logic                rej_r, rej_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [SEC_W-1:0]    out_sec_r, out_sec_nxt;
  logic                out_ok_r, out_ok_nxt;

  // shared unit operands
  logic [8:0]          mul_a;
  logic [INYEAR_W-1:0] mul_b;
  logic                mul_clr, mul_sub;
  logic [34:0]         prod;
  logic [SEC_W-1:0]    unit_res;

  logic                in_acc, out_free;
  logic [6:0]          lh_adj, nh_adj;
  logic [7:0]          span;
  logic [5:0]          leap_cnt;

  assign in_stall            = (state_r != S_IDLE);
  assign in_acc              = in_valid && !in_stall;
  assign out_valid           = out_valid_r;
  assign out_elapsed_seconds = out_sec_r;
  assign out_elapsed_valid   = out_ok_r;
  assign out_free            = !out_valid_r || !out_stall;

  // twelve-hour fix-up only when both hour bytes are in twelve-hour mode
  always_comb begin
    lh_adj = in_last_hour_raw;
    nh_adj = in_now_hour_raw;
    if ((in_last_hour_raw & HOUR_12H_BIT) != 7'd0 &&
        (in_now_hour_raw & HOUR_12H_BIT) != 7'd0) begin
      if ((in_now_hour_raw & HOUR_PM_BIT) != 7'd0) begin
        nh_adj = (in_now_hour_raw & HOUR_MASK) + HOUR_PM_ADD;
      end
      if ((in_last_hour_raw & HOUR_PM_BIT) != 7'd0) begin
        lh_adj = (in_last_hour_raw & HOUR_MASK) + HOUR_PM_ADD;
      end
    end
  end

  // year span and count of leap years strictly between the two
  assign span = ny_r - ly_r;
  always_comb begin
    logic [7:0] hi_q;
    logic [7:0] lo_q;
    hi_q = (ny_r - 8'd1) >> 2;
    lo_q = ly_r >> 2;
    leap_cnt = (ny_r > ly_r) ? 6'(hi_q - lo_q) : 6'd0;
  end

  // operand select for the shared multiply-accumulate unit
  always_comb begin
    mul_a   = 9'd0;
    mul_b   = '0;
    mul_clr = 1'b0;
    mul_sub = 1'b0;
    case (state_r)
      S_L_DAY:  begin mul_a = lday_r;         mul_b = SECS_PER_DAY;  mul_clr = 1'b1; end
      S_L_HR:   begin mul_a = {1'b0, lhr_r};  mul_b = SECS_PER_HOUR; end
      S_L_MIN:  begin mul_a = {1'b0, lmin_r}; mul_b = SECS_PER_MIN;  end
      S_L_SEC:  begin mul_a = {1'b0, lsec_r}; mul_b = 26'd1;         end
      S_N_DAY:  begin mul_a = nday_r;         mul_b = SECS_PER_DAY;  mul_clr = 1'b1; end
      S_N_HR:   begin mul_a = {1'b0, nhr_r};  mul_b = SECS_PER_HOUR; end
      S_N_MIN:  begin mul_a = {1'b0, nmin_r}; mul_b = SECS_PER_MIN;  end
      S_N_SEC:  begin mul_a = {1'b0, nsec_r}; mul_b = 26'd1;         end
      S_D_YEAR: begin mul_a = {1'b0, span};   mul_b = SECS_PER_YEAR; mul_clr = 1'b1; end
      S_D_NOW:  begin mul_a = 9'd1;           mul_b = ns_r;          end
      S_D_LAST: begin mul_a = 9'd1;           mul_b = ls_r;          mul_sub = 1'b1; end
      S_D_LEAP: begin mul_a = {3'b0, leap_cnt}; mul_b = SECS_PER_DAY; end
      default:  begin mul_a = 9'd0;           mul_b = '0;            end
    endcase
  end

  // shared unit: acc (or zero when cleared) +/- a*b, modulo 2^32
  always_comb begin
    logic [SEC_W-1:0] base;
    base     = mul_clr ? '0 : acc_r;
    prod     = 35'(mul_a) * 35'(mul_b);
    unit_res = mul_sub ? base - prod[SEC_W-1:0] : base + prod[SEC_W-1:0];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ly_nxt        = ly_r;
    ny_nxt        = ny_r;
    lday_nxt      = lday_r;
    nday_nxt      = nday_r;
    lhr_nxt       = lhr_r;
    nhr_nxt       = nhr_r;
    lmin_nxt      = lmin_r;
    nmin_nxt      = nmin_r;
    lsec_nxt      = lsec_r;
    nsec_nxt      = nsec_r;
    ls_nxt        = ls_r;
    ns_nxt        = ns_r;
    acc_nxt       = acc_r;
    rej_nxt       = rej_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_sec_nxt   = out_sec_r;
    out_ok_nxt    = out_ok_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ly_nxt    = bcd_dec(in_last_year_bcd);
          ny_nxt    = bcd_dec(in_now_year_bcd);
          lday_nxt  = year_days(bcd_dec(in_last_year_bcd),
                                bcd_dec({3'b0, in_last_month_bcd}),
                                bcd_dec({2'b0, in_last_day_bcd}));
          nday_nxt  = year_days(bcd_dec(in_now_year_bcd),
                                bcd_dec({3'b0, in_now_month_bcd}),
                                bcd_dec({2'b0, in_now_day_bcd}));
          lhr_nxt   = bcd_dec({1'b0, lh_adj});
          nhr_nxt   = bcd_dec({1'b0, nh_adj});
          lmin_nxt  = bcd_dec({1'b0, in_last_minute_bcd});
          nmin_nxt  = bcd_dec({1'b0, in_now_minute_bcd});
          lsec_nxt  = bcd_dec({1'b0, in_last_second_bcd});
          nsec_nxt  = bcd_dec({1'b0, in_now_second_bcd});
          rej_nxt   = 1'b0;
          state_nxt = S_L_DAY;
        end
      end
      S_L_DAY:  begin acc_nxt = unit_res; state_nxt = S_L_HR;  end
      S_L_HR:   begin acc_nxt = unit_res; state_nxt = S_L_MIN; end
      S_L_MIN:  begin acc_nxt = unit_res; state_nxt = S_L_SEC; end
      S_L_SEC: begin
        ls_nxt    = unit_res[INYEAR_W-1:0];
        state_nxt = S_N_DAY;
      end
      S_N_DAY:  begin acc_nxt = unit_res; state_nxt = S_N_HR;  end
      S_N_HR:   begin acc_nxt = unit_res; state_nxt = S_N_MIN; end
      S_N_MIN:  begin acc_nxt = unit_res; state_nxt = S_N_SEC; end
      S_N_SEC: begin
        ns_nxt    = unit_res[INYEAR_W-1:0];
        state_nxt = S_D_YEAR;
      end
      // earlier year or earlier in-year time rejects the item
      S_D_YEAR: begin
        acc_nxt = unit_res;
        if (ny_r < ly_r || ns_r < ls_r) begin
          rej_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_D_NOW;
        end
      end
      S_D_NOW:  begin acc_nxt = unit_res; state_nxt = S_D_LAST; end
      S_D_LAST: begin acc_nxt = unit_res; state_nxt = S_D_LEAP; end
      S_D_LEAP: begin acc_nxt = unit_res; state_nxt = S_DONE;   end
      // move the result once the output register is free
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sec_nxt   = rej_r ? REJECT_VALUE : acc_r;
          out_ok_nxt    = !rej_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ly_r      <= ly_nxt;
    ny_r      <= ny_nxt;
    lday_r    <= lday_nxt;
    nday_r    <= nday_nxt;
    lhr_r     <= lhr_nxt;
    nhr_r     <= nhr_nxt;
    lmin_r    <= lmin_nxt;
    nmin_r    <= nmin_nxt;
    lsec_r    <= lsec_nxt;
    nsec_r    <= nsec_nxt;
    ls_r      <= ls_nxt;
    ns_r      <= ns_nxt;
    acc_r     <= acc_nxt;
    rej_r     <= rej_nxt;
    out_sec_r <= out_sec_nxt;
    out_ok_r  <= out_ok_nxt;
  end

  // checks
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_L_DAY)
    else $error("accepted item did not start the sequencer");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result loaded outside the final step");

  a_reject_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ok_r |-> out_sec_r == REJECT_VALUE)
    else $error("rejected item carries a wrong value");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_sec_r))
    else $error("held result lost or changed");

endmodule

`default_nettype wire
